### design/afl_pkg.sv
package afl_pkg;
   typedef enum logic [2:0] {
      KIND_LOAD_W  = 3'd0,
      KIND_LOAD_B  = 3'd1,
      KIND_FWD     = 3'd2,
      KIND_BWD     = 3'd3,
      KIND_READ_DW = 3'd4,
      KIND_READ_DB = 3'd5
   } kind_type;

   localparam int ACC_W = 40;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > $signed({{(ACC_W-32){1'b0}}, 32'h7fffffff})) sat32 = 32'h7fffffff;
      else if (v < $signed({{(ACC_W-32){1'b1}}, 32'h80000000})) sat32 = 32'h80000000;
      else sat32 = v[31:0];
   endfunction
endpackage

### design/afl_if.sv
interface afl_req_if;
   logic              valid;
   logic              ready;
   logic [2:0]        kind;
   logic [3:0]        row;
   logic [3:0]        col;
   logic signed [15:0] value;
   modport source (output valid, kind, row, col, value, input ready);
   modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface afl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result;
   logic [3:0]         index;
   logic               last;
   modport source (output valid, result, index, last, input ready);
   modport sink   (input valid, result, index, last, output ready);
endinterface

### design/affine_layer_forward_backward.sv
// Dense-layer engine with forward and backward passes, Q4.12 operands.
// The req channel carries one beat per item: kind, row, col and value.
// Loads, non-completing elements and ignored items are absorbed and give
// no rsp beat. Each of the NC cells keeps one column and one row of the
// weight matrix and owns one output or input-gradient sum.
// A completing forward element starts operand reads, one per input; each
// cell adds one product a cycle from its registered reads. A completing
// backward item first forms the input-gradient sums, one operand per
// output, and then updates the weight-gradient memory one entry a cycle
// through a single read and write port; the last write lands in the first
// output cycle.
// The cell row then shifts its sums out, one rsp beat each, with last on the
// final beat. A read of dW or db is staged in S_READ before its beat shows.
// The next req beat is taken only once the final rsp beat has been delivered.
// Reset clears control state and db and marks dW as cleared, so dW reads as
// zero until the next weight-gradient pass rewrites every entry. A backward
// item at row 0, col 0 clears db at once and marks dW the same way.
// When rsp is stalled, the block holds its beat and the cell row waits.
module affine_layer_forward_backward import afl_pkg::*; #(
   parameter int IN_DIM  = 16,
   parameter int OUT_DIM = 16,
   parameter int BATCH   = 8
) (
   input  logic      clock,
   input  logic      reset,
   afl_req_if.sink   req,
   afl_rsp_if.source rsp
);
   localparam int NC = (IN_DIM > OUT_DIM) ? IN_DIM : OUT_DIM;

   typedef enum logic [2:0] {S_IDLE, S_FWD, S_BWD, S_DW, S_OUT, S_READ} state_type;

   logic signed [15:0] b_mem [16];
   logic signed [15:0] x_mem [16*16];
   logic signed [15:0] g_mem [16];
   logic signed [31:0] dw_mem [16*16];
   logic               dw_clr_ff;
   logic signed [31:0] db_ff [16];

   state_type  st_ff;
   logic [3:0] cnt_ff, row_ff;
   logic [7:0] k_ff;
   logic [3:0] out_n_ff;
   logic [3:0] emit_ff;
   logic       rv_ff;
   logic signed [31:0] rr_ff;
   logic [3:0] ri_ff;
   logic       rl_ff;
   logic       rd_dw_ff, rd_ok_ff;
   logic       mac_ff, dv_ff;
   logic signed [15:0] a_ff, gd_ff;
   logic signed [31:0] dw_rd_ff;
   logic [7:0] dk_ff;

   logic       acc;
   logic [2:0] kd;
   logic [3:0] rw, cl;
   logic signed [15:0] vl;
   assign kd = req.kind; assign rw = req.row; assign cl = req.col; assign vl = req.value;
   assign req.ready = (st_ff == S_IDLE) && !rv_ff;
   assign acc = req.valid && req.ready;

   // cell row
   logic              c_start, c_load, c_fwd, c_shift;
   logic signed [31:0] c_sum [NC];
   logic signed [31:0] c_init [NC];

   genvar gi;
   for (gi = 0; gi < NC; gi++) begin : g_cell
      afl_cell u_cell (
         .clock(clock), .idx(4'(gi)), .load(c_load), .load_row(rw), .load_col(cl),
         .load_value(vl), .tap(cnt_ff), .fwd(c_fwd), .start(c_start),
         .init(c_init[gi]), .mac(mac_ff), .a(a_ff), .shift(c_shift),
         .neighbor((gi == NC-1) ? 32'sd0 : c_sum[(gi+1) % NC]), .sum(c_sum[gi]));
      always_comb begin
         c_init[gi] = 32'sd0;
         if (st_ff == S_IDLE && kd == KIND_FWD && gi < OUT_DIM) c_init[gi] = 32'(b_mem[gi]);
      end
   end
   assign c_start = acc && ((kd == KIND_FWD && rw < BATCH && cl == IN_DIM-1) ||
                           (kd == KIND_BWD && rw < BATCH && cl == OUT_DIM-1));
   assign c_load  = acc && kd == KIND_LOAD_W && rw < IN_DIM && cl < OUT_DIM;
   assign c_fwd   = (st_ff == S_FWD);
   assign c_shift = (st_ff == S_OUT) && !mac_ff && (!rv_ff || rsp.ready);

   // dW update operands, registered from their reads
   logic [3:0] di, dj;
   logic signed [31:0] dprod, dold;
   logic [7:0] x_addr, dw_addr;
   logic       dw_done;
   assign di = k_ff[7:4]; assign dj = k_ff[3:0];
   assign x_addr  = (st_ff == S_DW) ? {row_ff, di} : {row_ff, cnt_ff};
   assign dw_addr = (st_ff == S_DW) ? k_ff : {rw, cl};
   assign dw_done = dv_ff && (dk_ff == {4'(IN_DIM-1), 4'(OUT_DIM-1)});
   always_comb begin
      dprod = (32'(a_ff) * 32'(gd_ff)) >>> 12;
      dold  = dw_clr_ff ? 32'sd0 : dw_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         if (kd == KIND_LOAD_B && cl < OUT_DIM) b_mem[cl] <= vl;
         if (kd == KIND_FWD && rw < BATCH && cl < IN_DIM) x_mem[{rw, cl}] <= vl;
         if (kd == KIND_BWD && rw < BATCH && cl < OUT_DIM) g_mem[cl] <= vl;
      end
      a_ff     <= (st_ff == S_BWD) ? g_mem[cnt_ff] : x_mem[x_addr];
      gd_ff    <= g_mem[dj];
      dw_rd_ff <= dw_mem[dw_addr];
      dk_ff    <= k_ff;
      if (dv_ff) dw_mem[dk_ff] <= sat32(ACC_W'(dold) + ACC_W'(dprod));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0; cnt_ff <= '0; k_ff <= '0;
         emit_ff <= '0; dw_clr_ff <= 1'b1; mac_ff <= 1'b0; dv_ff <= 1'b0;
         for (int n = 0; n < 16; n++) db_ff[n] <= 32'sd0;
      end else begin
         mac_ff <= (st_ff == S_FWD) || (st_ff == S_BWD);
         dv_ff  <= (st_ff == S_DW);
         if (dw_done) dw_clr_ff <= 1'b0;
         if (rv_ff && rsp.ready && !c_shift) rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (acc) begin
               row_ff <= rw; cnt_ff <= '0;
               unique case (kd)
                  KIND_FWD: if (c_start) begin
                     st_ff <= S_FWD; out_n_ff <= 4'(OUT_DIM-1);
                  end
                  KIND_BWD: if (rw < BATCH && cl < OUT_DIM) begin
                     if (rw == 0 && cl == 0) begin
                        dw_clr_ff <= 1'b1;
                        for (int n = 0; n < 16; n++) db_ff[n] <= 32'sd0;
                     end
                     if (c_start) begin
                        st_ff <= S_BWD; out_n_ff <= 4'(IN_DIM-1);
                     end
                  end
                  KIND_READ_DW: begin
                     rd_ok_ff <= rw < IN_DIM && cl < OUT_DIM && !dw_clr_ff;
                     rd_dw_ff <= 1'b1;
                     ri_ff <= cl; rl_ff <= 1'b1; st_ff <= S_READ;
                  end
                  KIND_READ_DB: begin
                     rr_ff <= (cl < OUT_DIM) ? db_ff[cl] : 32'sd0;
                     rd_dw_ff <= 1'b0;
                     ri_ff <= cl; rl_ff <= 1'b1; st_ff <= S_READ;
                  end
                  default: ;
               endcase
            end
            S_READ: begin
               if (rd_dw_ff) rr_ff <= rd_ok_ff ? dw_rd_ff : 32'sd0;
               rv_ff <= 1'b1; st_ff <= S_IDLE;
            end
            S_FWD: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(IN_DIM-1)) begin st_ff <= S_OUT; emit_ff <= '0; end
            end
            S_BWD: begin
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'(OUT_DIM-1)) begin
                  st_ff <= S_DW; k_ff <= '0;
                  for (int n = 0; n < 16; n++)
                     if (n < OUT_DIM)
                        db_ff[n] <= sat32(ACC_W'(db_ff[n]) + ACC_W'(g_mem[n]));
               end
            end
            S_DW: begin
               if (dj == 4'(OUT_DIM-1)) begin
                  if (di == 4'(IN_DIM-1)) begin st_ff <= S_OUT; emit_ff <= '0; end
                  else k_ff <= {di + 4'd1, 4'd0};
               end else k_ff <= k_ff + 8'd1;
            end
            S_OUT: if (c_shift) begin
               rv_ff <= 1'b1; rr_ff <= c_sum[0]; ri_ff <= emit_ff;
               rl_ff <= (emit_ff == out_n_ff);
               emit_ff <= emit_ff + 4'd1;
               if (emit_ff == out_n_ff) st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp.valid  = rv_ff;
   assign rsp.result = rr_ff;
   assign rsp.index  = ri_ff;
   assign rsp.last   = rl_ff;
endmodule

### design/afl_cell.sv
// One multiply-accumulate cell: keeps column idx and row idx of the weight
// matrix and accumulates shifted products for one output or input-gradient sum.
module afl_cell import afl_pkg::*; (
   input  logic                     clock,
   input  logic [3:0]               idx,
   input  logic                     load,
   input  logic [3:0]               load_row,
   input  logic [3:0]               load_col,
   input  logic signed [15:0]       load_value,
   input  logic [3:0]               tap,
   input  logic                     fwd,
   input  logic                     start,
   input  logic signed [31:0]       init,
   input  logic                     mac,
   input  logic signed [15:0]       a,
   input  logic                     shift,
   input  logic signed [31:0]       neighbor,
   output logic signed [31:0]       sum
);
   logic signed [15:0]      wcol_mem [16];
   logic signed [15:0]      wrow_mem [16];
   logic signed [15:0]      w_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [31:0]      prod;

   // The forward pass walks the column, the backward pass walks the row.
   always_ff @(posedge clock) begin
      if (load && load_col == idx) wcol_mem[load_row] <= load_value;
      if (load && load_row == idx) wrow_mem[load_col] <= load_value;
      w_ff <= fwd ? wcol_mem[tap] : wrow_mem[tap];
   end

   always_comb begin
      prod = (32'(a) * 32'(w_ff)) >>> 12;
      acc_in = acc_ff;
      if (start) acc_in = ACC_W'(init);
      else if (mac) acc_in = acc_ff + ACC_W'(prod);
      else if (shift) acc_in = ACC_W'(neighbor);
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign sum = sat32(acc_ff);
endmodule
